### hdl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// shared types, constants and the digit segment table for the text to
// seven-segment decoder
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned NumDisplaysDefault = 8;
  localparam int unsigned Digits             = 4;
  localparam int unsigned QueueDepth         = 2;

  localparam int unsigned CharW  = 8;
  localparam int unsigned IndexW = 3;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned StoreW = Digits * CodeW;

  localparam logic [CodeW-1:0] SegBlank = 8'h00;
  localparam logic [CodeW-1:0] SegDash  = 8'h01;
  localparam logic [CodeW-1:0] SegPoint = 8'h80;

  localparam logic [2:0] PlaceMax    = 3'd7;
  localparam logic [1:0] PointMax    = 2'd3;
  localparam logic [3:0] HexCountMax = 4'd15;
  localparam logic [3:0] HexDigits   = 4'(2 * Digits);
  localparam logic [2:0] PlaceLimit  = 3'(Digits);

  typedef enum logic [2:0] {
    TOK_TERM,
    TOK_DIGIT,
    TOK_HEX_LETTER,
    TOK_POINT,
    TOK_MINUS,
    TOK_HEX_PREFIX,
    TOK_OTHER
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e         kind;
    logic [3:0]        value;
    logic [IndexW-1:0] display_index;
  } token_t;

  function automatic logic [CodeW-1:0] digit_segs(input logic [3:0] d);
    logic [CodeW-1:0] s;
    unique case (d)
      4'd0:    s = 8'h7E;
      4'd1:    s = 8'h30;
      4'd2:    s = 8'h6D;
      4'd3:    s = 8'h79;
      4'd4:    s = 8'h33;
      4'd5:    s = 8'h5B;
      4'd6:    s = 8'h5F;
      4'd7:    s = 8'h70;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h7B;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

### hdl/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front
// input side: takes one character word and sorts it into a token for the
// parser queue
// ----------------------------------------------------------------------------
module tts_front (
  input  logic [tts_pkg::CharW-1:0]  character_i,
  input  logic [tts_pkg::IndexW-1:0] display_index_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output tts_pkg::token_t            q_token_o
);

  tts_pkg::tok_kind_e kind;
  logic [3:0]         value;

  always_comb begin
    kind  = tts_pkg::TOK_OTHER;
    value = '0;
    if (character_i == 8'h00) begin
      kind = tts_pkg::TOK_TERM;
    end else if (character_i >= 8'h30 && character_i <= 8'h39) begin
      kind  = tts_pkg::TOK_DIGIT;
      value = 4'(character_i - 8'h30);
    end else if (character_i >= 8'h61 && character_i <= 8'h66) begin
      kind  = tts_pkg::TOK_HEX_LETTER;
      value = 4'(character_i - 8'h57);
    end else if (character_i >= 8'h41 && character_i <= 8'h46) begin
      kind  = tts_pkg::TOK_HEX_LETTER;
      value = 4'(character_i - 8'h37);
    end else if (character_i == 8'h2E) begin
      kind = tts_pkg::TOK_POINT;
    end else if (character_i == 8'h2D) begin
      kind = tts_pkg::TOK_MINUS;
    end else if (character_i == 8'h68 || character_i == 8'h48) begin
      kind = tts_pkg::TOK_HEX_PREFIX;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign q_token_o.kind          = kind;
  assign q_token_o.value         = value;
  assign q_token_o.display_index = display_index_i;

endmodule

### hdl/tts_queue.sv
// ----------------------------------------------------------------------------
// tts_queue
// short token queue between the classifier and the parser
// ----------------------------------------------------------------------------
module tts_queue #(
  parameter int unsigned Depth = tts_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tts_pkg::token_t push_token_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tts_pkg::token_t pop_token_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tts_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o      = (cnt_q == CntW'(Depth));
  assign valid_o     = (cnt_q != '0);
  assign pop_token_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_token_i;
    end
  end

endmodule

### hdl/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back
// parser: builds the code store from tokens and registers the result word
// on the terminator
// ----------------------------------------------------------------------------
module tts_back #(
  parameter int unsigned NumDisplays = tts_pkg::NumDisplaysDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  tts_pkg::token_t            q_token_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tts_pkg::IndexW-1:0] display_index_res_o,
  output logic                       ok_o,
  output logic [tts_pkg::CodeW-1:0]  code_left_o,
  output logic [tts_pkg::CodeW-1:0]  code_mid_left_o,
  output logic [tts_pkg::CodeW-1:0]  code_mid_right_o,
  output logic [tts_pkg::CodeW-1:0]  code_right_o
);

  localparam int unsigned CmpW = 10;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NATURAL,
    PH_HEX,
    PH_REJECT
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [tts_pkg::StoreW-1:0] store_q, store_d;
  logic [2:0]                 place_q, place_d;
  logic [1:0]                 point_q, point_d;
  logic [3:0]                 hex_cnt_q, hex_cnt_d;

  logic                       out_valid_q, out_valid_d;
  logic [tts_pkg::IndexW-1:0] idx_q, idx_d;
  logic                       ok_q, ok_d;
  logic [tts_pkg::StoreW-1:0] res_q, res_d;

  logic is_term;
  logic slot_free;
  logic ok_raw;
  logic in_range;

  assign is_term   = (q_token_i.kind == tts_pkg::TOK_TERM);
  assign slot_free = !out_valid_q || out_ready_i;
  assign q_pop_o   = q_valid_i && (!is_term || slot_free);
  assign in_range  = (CmpW'(q_token_i.display_index) < CmpW'(NumDisplays));

  always_comb begin
    unique case (phase_q)
      PH_HEX:    ok_raw = (hex_cnt_q == tts_pkg::HexDigits);
      PH_REJECT: ok_raw = 1'b0;
      default:   ok_raw = (place_q <= tts_pkg::PlaceLimit) && (point_q <= 2'd1);
    endcase
  end

  always_comb begin
    logic              natural;
    logic [1:0]        pt_next;
    logic [tts_pkg::CodeW-1:0] push_val;
    logic              do_push;

    phase_d     = phase_q;
    store_d     = store_q;
    place_d     = place_q;
    point_d     = point_q;
    hex_cnt_d   = hex_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    idx_d       = idx_q;
    ok_d        = ok_q;
    res_d       = res_q;
    natural     = 1'b0;
    do_push     = 1'b0;
    push_val    = tts_pkg::SegBlank;
    pt_next     = (point_q < tts_pkg::PointMax) ? point_q + 1'b1 : point_q;

    if (q_pop_o) begin
      if (is_term) begin
        out_valid_d = 1'b1;
        idx_d       = q_token_i.display_index;
        ok_d        = ok_raw && in_range;
        res_d       = (ok_raw && in_range) ? store_q : '0;
        phase_d     = PH_IDLE;
        store_d     = '0;
        place_d     = '0;
        point_d     = '0;
        hex_cnt_d   = '0;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (q_token_i.kind == tts_pkg::TOK_HEX_PREFIX) begin
              phase_d = PH_HEX;
            end else if (q_token_i.kind == tts_pkg::TOK_MINUS) begin
              phase_d  = PH_NATURAL;
              do_push  = 1'b1;
              push_val = tts_pkg::SegDash;
            end else begin
              phase_d = PH_NATURAL;
              natural = 1'b1;
            end
          end
          PH_NATURAL: natural = 1'b1;
          PH_HEX: begin
            if (q_token_i.kind == tts_pkg::TOK_DIGIT ||
                q_token_i.kind == tts_pkg::TOK_HEX_LETTER) begin
              store_d = {store_q[tts_pkg::StoreW-5:0], q_token_i.value};
              if (hex_cnt_q < tts_pkg::HexCountMax) begin
                hex_cnt_d = hex_cnt_q + 1'b1;
              end
            end else begin
              phase_d = PH_REJECT;
            end
          end
          default: ;
        endcase

        if (natural) begin
          case (q_token_i.kind)
            tts_pkg::TOK_DIGIT: begin
              do_push  = 1'b1;
              push_val = tts_pkg::digit_segs(q_token_i.value);
            end
            tts_pkg::TOK_POINT: begin
              point_d = pt_next;
              if (pt_next > 2'd1) begin
                phase_d = PH_REJECT;
              end else if (place_q == '0) begin
                do_push  = 1'b1;
                push_val = tts_pkg::SegBlank | tts_pkg::SegPoint;
              end else begin
                store_d = store_q | tts_pkg::StoreW'(tts_pkg::SegPoint);
              end
            end
            default: phase_d = PH_REJECT;
          endcase
        end

        if (do_push) begin
          store_d = {store_q[tts_pkg::StoreW-tts_pkg::CodeW-1:0], push_val};
          if (place_q < tts_pkg::PlaceMax) begin
            place_d = place_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      store_q     <= '0;
      place_q     <= '0;
      point_q     <= '0;
      hex_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      ok_q        <= 1'b0;
      res_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      store_q     <= store_d;
      place_q     <= place_d;
      point_q     <= point_d;
      hex_cnt_q   <= hex_cnt_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      ok_q        <= ok_d;
      res_q       <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign display_index_res_o = idx_q;
  assign ok_o                = ok_q;
  assign code_left_o         = res_q[31:24];
  assign code_mid_left_o     = res_q[23:16];
  assign code_mid_right_o    = res_q[15:8];
  assign code_right_o        = res_q[7:0];

endmodule

### hdl/text_to_seven_segment.sv
// ----------------------------------------------------------------------------
// text_to_seven_segment
// turns a zero-terminated character string into four seven-segment codes
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o   character_i, display_index_i
//   out      output     out_valid_o/out_ready_i display_index_res_o, ok_o,
//                                               code_left_o .. code_right_o
//
// one character word is taken every cycle while the two-entry token queue
// has room; the parser drains one token a cycle unless a terminator waits.
// a terminator's result word is registered in the cycle after the parser pops it.
// a held result stops the next terminator at the queue head; characters
// ahead of it keep flowing into the parser, the input stalls once the queue
// fills.
// reset clears all parse state and the output register at once.
// ----------------------------------------------------------------------------
module text_to_seven_segment #(
  parameter int unsigned NumDisplays = tts_pkg::NumDisplaysDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tts_pkg::CharW-1:0]  character_i,
  input  logic [tts_pkg::IndexW-1:0] display_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tts_pkg::IndexW-1:0] display_index_res_o,
  output logic                       ok_o,
  output logic [tts_pkg::CodeW-1:0]  code_left_o,
  output logic [tts_pkg::CodeW-1:0]  code_mid_left_o,
  output logic [tts_pkg::CodeW-1:0]  code_mid_right_o,
  output logic [tts_pkg::CodeW-1:0]  code_right_o
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  tts_pkg::token_t push_token;
  tts_pkg::token_t pop_token;

  tts_front u_front (
    .character_i     (character_i),
    .display_index_i (display_index_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_token_o       (push_token)
  );

  tts_queue #(
    .Depth (tts_pkg::QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_token_i (push_token),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_token_o  (pop_token)
  );

  tts_back #(
    .NumDisplays (NumDisplays)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_token_i           (pop_token),
    .q_pop_o             (q_pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .display_index_res_o (display_index_res_o),
    .ok_o                (ok_o),
    .code_left_o         (code_left_o),
    .code_mid_left_o     (code_mid_left_o),
    .code_mid_right_o    (code_mid_right_o),
    .code_right_o        (code_right_o)
  );

  // rejected word carries blank codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |->
      (code_left_o == '0 && code_mid_left_o == '0 &&
       code_mid_right_o == '0 && code_right_o == '0))
    else $error("rejected word with non-zero codes");

  // display outside the range never accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (32'(display_index_res_o) >= NumDisplays)) |-> !ok_o)
    else $error("out of range display accepted");

  // no push into a full queue and no pop from an empty one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full) && !(q_pop && !q_valid))
    else $error("token queue overrun or underrun");

  // a terminator only leaves the queue when the output slot can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && pop_token.kind == tts_pkg::TOK_TERM) |=> out_valid_o)
    else $error("terminator popped without a result word");

endmodule
